@@ design/irtpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irtpd_pkg
// Shared types and constants for the self-calibrating IR press detector.
// ----------------------------------------------------------------------------
package irtpd_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_MAX_STEP       = 3'd0,
        CFG_WINDOW_SAMPLES = 3'd1,
        CFG_SLOPE_Q8_8     = 3'd2,
        CFG_OFFSET         = 3'd3,
        CFG_BASELINE_LIMIT = 3'd4,
        CFG_PRESS_SAMPLES  = 3'd5,
        CFG_LONG_PRESS_MS  = 3'd6,
        CFG_LOCKOUT_MS     = 3'd7
    } cfg_idx_t;

    localparam int CFG_DATA_BITS = 16;

    // register reset values
    localparam logic [9:0]  MAX_STEP_RST       = 10'd20;
    localparam logic [7:0]  WINDOW_SAMPLES_RST = 8'd10;
    localparam logic [15:0] SLOPE_RST          = 16'd256;
    localparam logic [15:0] OFFSET_RST         = 16'd100;
    localparam logic [10:0] BASELINE_LIMIT_RST = 11'd900;
    localparam logic [7:0]  PRESS_SAMPLES_RST  = 8'd5;
    localparam logic [15:0] LONG_PRESS_MS_RST  = 16'd3000;
    localparam logic [15:0] LOCKOUT_MS_RST     = 16'd1500;

    // release gaps
    localparam logic [31:0] GAP_HELD_MS  = 32'd200;
    localparam logic [31:0] GAP_COUNT_MS = 32'd500;

    // one result request
    typedef struct packed {
        logic        held;
        logic [15:0] threshold;
        logic        first_calib;
        logic        calib_gained;
        logic        is_calibrated;
        logic        press_event;
    } result_t;

    localparam int RESULT_BITS  = $bits(result_t);
    localparam int RESULT_TDATA = ((RESULT_BITS + 7) / 8) * 8;

endpackage

@@ design/irtpd_thresh.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irtpd_thresh
// Threshold from baseline midpoint: floor(mid * slope / 256) + offset,
// saturated to 0..65535.
// ----------------------------------------------------------------------------
module irtpd_thresh #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic [SAMPLE_BITS:0] mid,
    input  logic [15:0]          slope_q8_8,
    input  logic [15:0]          offset,
    output logic [15:0]          threshold
);

    localparam int PW = SAMPLE_BITS + 18;
    localparam int TW = PW + 1;

    logic signed [PW-1:0] mid_s;
    logic signed [PW-1:0] slope_s;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_floor;
    logic signed [TW-1:0] total;

    assign mid_s      = $signed({{(PW-SAMPLE_BITS-1){1'b0}}, mid});
    assign slope_s    = $signed({{(PW-16){slope_q8_8[15]}}, slope_q8_8});
    assign prod       = mid_s * slope_s;
    // arithmetic shift floors toward minus infinity
    assign prod_floor = prod >>> 8;
    assign total      = $signed({prod_floor[PW-1], prod_floor})
                      + $signed({{(TW-16){1'b0}}, offset});

    always_comb
    begin
        if (total[TW-1])
        begin
            threshold = 16'h0000;
        end
        else if (|total[TW-2:16])
        begin
            threshold = 16'hFFFF;
        end
        else
        begin
            threshold = total[15:0];
        end
    end

endmodule

@@ design/ir_touch_autocal_press_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_touch_autocal_press_detector
// Self-calibrating IR touch sensor press detector with baseline tracking.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the result stream is not stalled: an IR
// sample with its millisecond timestamp. Every request yields exactly one
// result request. A request sits in an input register, then one pass of logic
// (baseline window, threshold multiply, press counting) updates the detector
// state and loads the result register, so the block sustains one request per
// clock while m_tready is not held low; the state update loop (window plus the
// threshold multiply feeding the press compare) closes in that pass. The input
// side keeps accepting while a result waits, as long as the result register
// is drained or about to be. Configuration is written through cfg_we /
// cfg_index / cfg_data and should only change while the block is idle.
// ----------------------------------------------------------------------------
module ir_touch_autocal_press_detector #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_index,
    input  logic [irtpd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    // sample stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: sample [SAMPLE_BITS-1:0], now_ms [SAMPLE_BITS+31:SAMPLE_BITS]
    input  logic [((SAMPLE_BITS+32+7)/8)*8-1:0] s_tdata,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata: press_event [0], is_calibrated [1], calib_gained [2],
    // first_calib [3], threshold [19:4], held [20]
    output logic [irtpd_pkg::RESULT_TDATA-1:0]  m_tdata
);

    localparam int SB = SAMPLE_BITS;
    // widths for compares against the fixed-width registers
    localparam int DW = (SB > 10) ? SB : 10;
    localparam int MW = (SB + 1 > 11) ? SB + 1 : 11;
    localparam logic [SB:0] WIN_MIN_RST = (SB+1)'((1 << SB) + 1);

    // ---------------------------------------------------------------- config
    logic [9:0]  max_step_reg;
    logic [7:0]  window_samples_reg;
    logic [15:0] slope_reg;
    logic [15:0] offset_reg;
    logic [10:0] baseline_limit_reg;
    logic [7:0]  press_samples_reg;
    logic [15:0] long_press_ms_reg;
    logic [15:0] lockout_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg       <= irtpd_pkg::MAX_STEP_RST;
            window_samples_reg <= irtpd_pkg::WINDOW_SAMPLES_RST;
            slope_reg          <= irtpd_pkg::SLOPE_RST;
            offset_reg         <= irtpd_pkg::OFFSET_RST;
            baseline_limit_reg <= irtpd_pkg::BASELINE_LIMIT_RST;
            press_samples_reg  <= irtpd_pkg::PRESS_SAMPLES_RST;
            long_press_ms_reg  <= irtpd_pkg::LONG_PRESS_MS_RST;
            lockout_ms_reg     <= irtpd_pkg::LOCKOUT_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (irtpd_pkg::cfg_idx_t'(cfg_index))
                irtpd_pkg::CFG_MAX_STEP:       max_step_reg       <= cfg_data[9:0];
                irtpd_pkg::CFG_WINDOW_SAMPLES: window_samples_reg <= cfg_data[7:0];
                irtpd_pkg::CFG_SLOPE_Q8_8:     slope_reg          <= cfg_data[15:0];
                irtpd_pkg::CFG_OFFSET:         offset_reg         <= cfg_data[15:0];
                irtpd_pkg::CFG_BASELINE_LIMIT: baseline_limit_reg <= cfg_data[10:0];
                irtpd_pkg::CFG_PRESS_SAMPLES:  press_samples_reg  <= cfg_data[7:0];
                irtpd_pkg::CFG_LONG_PRESS_MS:  long_press_ms_reg  <= cfg_data[15:0];
                irtpd_pkg::CFG_LOCKOUT_MS:     lockout_ms_reg     <= cfg_data[15:0];
                default:                       max_step_reg       <= max_step_reg;
            endcase
        end
    end

    // ----------------------------------------------------------- input stage
    logic          in_valid_reg;
    logic [SB-1:0] sample_reg;
    logic [31:0]   now_reg;
    logic          advance;

    // the stage moves whenever the result register is free or being drained
    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            sample_reg <= s_tdata[SB-1:0];
            now_reg    <= s_tdata[SB+31:SB];
        end
    end

    // --------------------------------------------------------- detector state
    logic [SB-1:0] last_sample_reg,   last_sample_next;
    logic [SB:0]   window_min_reg,    window_min_next;
    logic [SB-1:0] window_max_reg,    window_max_next;
    logic [7:0]    window_count_reg,  window_count_next;
    logic          calibrated_reg,    calibrated_next;
    logic          ever_cal_reg,      ever_cal_next;
    logic [15:0]   threshold_reg,     threshold_next;
    logic [7:0]    press_count_reg,   press_count_next;
    logic [31:0]   last_press_ms_reg, last_press_ms_next;
    logic [31:0]   press_start_reg,   press_start_next;
    logic [31:0]   calib_lock_reg,    calib_lock_next;
    logic [31:0]   press_lock_reg,    press_lock_next;

    // window stage intermediates
    logic [SB-1:0] diff;
    logic          stable;
    logic [7:0]    win_count1;
    logic [SB:0]   win_min1;
    logic [SB-1:0] win_max1;
    logic [SB+1:0] range;
    logic          range_wide;
    logic [SB+1:0] mid_sum;
    logic [SB:0]   mid;
    logic          mid_ok;
    logic [15:0]   new_threshold;
    logic          calib_run;

    // press stage intermediates
    logic          over;
    logic [7:0]    press_count1;
    logic          press_run;

    irtpd_pkg::result_t result_next;
    irtpd_pkg::result_t result_reg;
    logic               out_valid_reg;

    irtpd_thresh #(
        .SAMPLE_BITS (SB)
    ) u_thresh (
        .mid        (mid),
        .slope_q8_8 (slope_reg),
        .offset     (offset_reg),
        .threshold  (new_threshold)
    );

    // window arithmetic on the current request
    always_comb
    begin
        diff       = (sample_reg > last_sample_reg) ? sample_reg - last_sample_reg
                                                    : last_sample_reg - sample_reg;
        stable     = DW'(diff) < DW'(max_step_reg);
        if (stable)
        begin
            win_count1 = (window_count_reg != 8'hFF) ? window_count_reg + 8'd1
                                                     : window_count_reg;
            win_min1   = ({1'b0, sample_reg} < window_min_reg) ? {1'b0, sample_reg}
                                                               : window_min_reg;
            win_max1   = (sample_reg > window_max_reg) ? sample_reg : window_max_reg;
        end
        else
        begin
            // step too large: window restarts here
            win_count1 = 8'd0;
            win_min1   = {1'b0, sample_reg};
            win_max1   = sample_reg;
        end
        range      = {2'b00, win_max1} - {1'b0, win_min1};
        range_wide = !range[SB+1] && (MW'(range[SB:0]) >= MW'(max_step_reg));
        mid_sum    = {1'b0, win_min1} + {2'b00, win_max1};
        mid        = mid_sum[SB+1:1];
        mid_ok     = MW'(mid) < MW'(baseline_limit_reg);
    end

    // state update for one request
    always_comb
    begin
        last_sample_next   = last_sample_reg;
        window_min_next    = window_min_reg;
        window_max_next    = window_max_reg;
        window_count_next  = window_count_reg;
        calibrated_next    = calibrated_reg;
        ever_cal_next      = ever_cal_reg;
        threshold_next     = threshold_reg;
        press_count_next   = press_count_reg;
        last_press_ms_next = last_press_ms_reg;
        press_start_next   = press_start_reg;
        calib_lock_next    = calib_lock_reg;
        press_lock_next    = press_lock_reg;
        result_next        = '0;

        // baseline window: frozen while locked out or a press is in progress
        calib_run = !(now_reg < calib_lock_reg) && (press_count_reg == 8'd0);
        if (calib_run)
        begin
            window_count_next = win_count1;
            window_min_next   = win_min1;
            window_max_next   = win_max1;
            last_sample_next  = sample_reg;
            if (win_count1 >= window_samples_reg)
            begin
                if (range_wide)
                begin
                    // too wide to trust: restart, last sample kept
                    window_count_next = 8'd0;
                    window_min_next   = {1'b0, sample_reg};
                    window_max_next   = sample_reg;
                    last_sample_next  = last_sample_reg;
                end
                else
                begin
                    if (mid_ok)
                    begin
                        result_next.calib_gained = !calibrated_reg;
                        result_next.first_calib  = !ever_cal_reg;
                        calibrated_next          = 1'b1;
                        ever_cal_next            = 1'b1;
                        threshold_next           = new_threshold;
                    end
                    else
                    begin
                        calibrated_next = 1'b0;
                    end
                    window_count_next = 8'd0;
                    window_min_next   = WIN_MIN_RST;
                    window_max_next   = '0;
                end
            end
        end

        // press detection against the threshold after this step
        over         = 16'(sample_reg) >= threshold_next;
        press_count1 = press_count_reg + 8'd1;
        press_run    = ever_cal_next && calibrated_next && !(now_reg < press_lock_reg);
        if (press_run)
        begin
            if (press_count_reg == press_samples_reg)
            begin
                if (over)
                begin
                    last_press_ms_next = now_reg;
                    // long hold: auto-release and lock out
                    if (now_reg > press_start_reg + 32'(long_press_ms_reg))
                    begin
                        press_count_next = 8'd0;
                        calib_lock_next  = now_reg + 32'(lockout_ms_reg);
                        press_lock_next  = now_reg + 32'(lockout_ms_reg);
                    end
                end
                else if (now_reg > last_press_ms_reg + irtpd_pkg::GAP_HELD_MS)
                begin
                    press_count_next = 8'd0;
                end
            end
            else if (over)
            begin
                press_count_next   = press_count1;
                last_press_ms_next = now_reg;
                if (press_count1 == press_samples_reg)
                begin
                    press_start_next        = now_reg;
                    result_next.press_event = 1'b1;
                end
            end
            else if (now_reg > last_press_ms_reg + irtpd_pkg::GAP_COUNT_MS)
            begin
                press_count_next = 8'd0;
            end
        end

        result_next.is_calibrated = calibrated_next;
        result_next.threshold     = threshold_next;
        result_next.held          = press_count_next == press_samples_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg   <= '0;
            window_min_reg    <= WIN_MIN_RST;
            window_max_reg    <= '0;
            window_count_reg  <= '0;
            calibrated_reg    <= 1'b0;
            ever_cal_reg      <= 1'b0;
            threshold_reg     <= '0;
            press_count_reg   <= '0;
            last_press_ms_reg <= '0;
            press_start_reg   <= '0;
            calib_lock_reg    <= '0;
            press_lock_reg    <= '0;
        end
        else if (advance)
        begin
            last_sample_reg   <= last_sample_next;
            window_min_reg    <= window_min_next;
            window_max_reg    <= window_max_next;
            window_count_reg  <= window_count_next;
            calibrated_reg    <= calibrated_next;
            ever_cal_reg      <= ever_cal_next;
            threshold_reg     <= threshold_next;
            press_count_reg   <= press_count_next;
            last_press_ms_reg <= last_press_ms_next;
            press_start_reg   <= press_start_next;
            calib_lock_reg    <= calib_lock_next;
            press_lock_reg    <= press_lock_next;
        end
    end

    // ---------------------------------------------------------- result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = irtpd_pkg::RESULT_TDATA'(result_reg);

endmodule
